[rtl/core/etsc_pkg.sv]
// shared types and codes for the expression token syntax checker
package etsc_pkg;

    // token classes as delivered by the tokenizer
    typedef enum logic [2:0] {
        TK_VALUE  = 3'd0,
        TK_INFIX  = 3'd1,
        TK_PREFIX = 3'd2,
        TK_OPEN   = 3'd3,
        TK_CLOSE  = 3'd4,
        TK_END    = 3'd5
    } t_tok_kind;

    // status codes reported on the end marker
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_LEFT     = 4'd1;
    localparam logic [3:0] ST_OP_ON_OP    = 4'd2;
    localparam logic [3:0] ST_CLOSE_SHORT = 4'd3;
    localparam logic [3:0] ST_CLOSE_EMPTY = 4'd4;
    localparam logic [3:0] ST_UNCLOSED    = 4'd5;
    localparam logic [3:0] ST_END_SHORT   = 4'd6;
    localparam logic [3:0] ST_NOT_ONE     = 4'd7;
    localparam logic [3:0] ST_TOO_DEEP    = 4'd8;

    // control from the checker to the bracket stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctrl;

    // bracket stack status
    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_stat;

endpackage

[rtl/core/etsc_if.sv]
// valid/ready channels for tokens and status results

interface etsc_tok_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [3:0] operator_arity;

    modport source (output valid, output token_kind, output operator_arity, input ready);
    modport sink   (input valid, input token_kind, input operator_arity, output ready);
endinterface

interface etsc_stat_if;
    logic       valid;
    logic       ready;
    logic [3:0] status_code;

    modport source (output valid, output status_code, input ready);
    modport sink   (input valid, input status_code, output ready);
endinterface

[rtl/core/expression_token_syntax_checker.sv]
// top level of the expression token syntax checker
// One token is taken per clock cycle, back to back, with no gaps for brackets:
// counter updates and the stack push or pop all settle in the cycle of the request,
// because the bracket stack keeps a registered copy of its top entry next to a
// single-port pair memory. The status request for an end marker appears in the output
// register on the next cycle; the token side stalls only while that register holds a
// status that has not yet been taken. The stack memory needs no clearing pass, so
// tokens are taken from the first cycle after reset. Counters saturate at
// 2^COUNT_BITS - 1 and the first error is held until the end marker.
module expression_token_syntax_checker #(
    parameter int MAX_NESTING = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    etsc_tok_if.sink    i_tok,
    etsc_stat_if.source o_res
);

    localparam int CW = COUNT_BITS;

    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;
    logic [CW-1:0] r_need;
    logic [CW-1:0] n_need;
    logic [3:0]    r_err;
    logic [3:0]    n_err;
    logic          r_out_valid;
    logic [3:0]    r_status;
    logic [3:0]    w_status;

    logic                 w_acc;
    logic                 w_end;
    etsc_pkg::t_tok_kind  w_kind;
    etsc_pkg::t_stk_ctrl  w_ctrl;
    etsc_pkg::t_stk_stat  w_stat;
    logic [2*CW-1:0]      w_top;
    logic [CW-1:0]        w_out_left;
    logic [CW-1:0]        w_out_right;

    logic [CW:0]   w_left_inc;
    logic [CW-1:0] w_left_sat;
    logic [CW:0]   w_need_inc;
    logic [CW-1:0] w_need_sat;
    logic [CW-1:0] w_pre_need;
    logic [CW-1:0] w_pre_left;
    logic [CW:0]   w_pre_sum;
    logic [CW-1:0] w_pre_sat;
    logic          w_fits;
    logic [CW-1:0] w_diff;
    logic [CW:0]   w_fold_sum;
    logic [CW-1:0] w_fold_sat;

    // handshake
    assign o_res.valid       = r_out_valid;
    assign o_res.status_code = r_status;
    assign i_tok.ready       = !r_out_valid || o_res.ready;
    assign w_acc             = i_tok.valid && i_tok.ready;
    assign w_kind            = etsc_pkg::t_tok_kind'(i_tok.token_kind);
    assign w_end             = w_acc && (w_kind == etsc_pkg::TK_END);

    // bracket stack
    etsc_stack #(
        .DEPTH  (MAX_NESTING),
        .DATA_W (2 * CW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_push_data ({r_left, r_need}),
        .o_top_data  (w_top),
        .o_stat      (w_stat)
    );

    assign w_out_left  = w_top[2*CW-1:CW];
    assign w_out_right = w_top[CW-1:0];

    // saturating increments
    assign w_left_inc = {1'b0, r_left} + (CW+1)'(1);
    assign w_left_sat = w_left_inc[CW] ? {CW{1'b1}} : w_left_inc[CW-1:0];
    assign w_need_inc = {1'b0, r_need} + (CW+1)'(1);
    assign w_need_sat = w_need_inc[CW] ? {CW{1'b1}} : w_need_inc[CW-1:0];

    // prefix operator: consume one required value or add one found, then add arity
    assign w_pre_need = (r_need != '0) ? (r_need - CW'(1)) : r_need;
    assign w_pre_left = (r_need != '0) ? r_left : w_left_sat;
    assign w_pre_sum  = {1'b0, w_pre_need} + {{(CW-3){1'b0}}, i_tok.operator_arity};
    assign w_pre_sat  = w_pre_sum[CW] ? {CW{1'b1}} : w_pre_sum[CW-1:0];

    // closing bracket: fold inner values into the outer level
    assign w_fits     = (r_left <= w_out_right);
    assign w_diff     = r_left - w_out_right;
    assign w_fold_sum = {1'b0, w_out_left} + {1'b0, w_diff};
    assign w_fold_sat = w_fold_sum[CW] ? {CW{1'b1}} : w_fold_sum[CW-1:0];

    // status for the end marker
    always_comb begin
        priority if (r_err != etsc_pkg::ST_OK) begin
            w_status = r_err;
        end else if (!w_stat.empty) begin
            w_status = etsc_pkg::ST_UNCLOSED;
        end else if (r_need != '0) begin
            w_status = etsc_pkg::ST_END_SHORT;
        end else if (r_left != CW'(1)) begin
            w_status = etsc_pkg::ST_NOT_ONE;
        end else begin
            w_status = etsc_pkg::ST_OK;
        end
    end

    // token rules
    always_comb begin
        n_left = r_left;
        n_need = r_need;
        n_err  = r_err;
        w_ctrl = '0;
        if (w_end) begin
            n_left       = '0;
            n_need       = '0;
            n_err        = etsc_pkg::ST_OK;
            w_ctrl.clear = 1'b1;
        end else if (w_acc && (r_err == etsc_pkg::ST_OK)) begin
            unique case (w_kind)
                etsc_pkg::TK_VALUE: begin
                    if (r_need == '0) begin
                        n_left = w_left_sat;
                    end else begin
                        n_need = r_need - CW'(1);
                    end
                end
                etsc_pkg::TK_INFIX: begin
                    if ((r_left != '0) && (r_need == '0)) begin
                        n_need = w_need_sat;
                    end else if (r_left <= CW'(1)) begin
                        n_err = etsc_pkg::ST_NO_LEFT;
                    end else begin
                        n_err = etsc_pkg::ST_OP_ON_OP;
                    end
                end
                etsc_pkg::TK_PREFIX: begin
                    n_left = w_pre_left;
                    n_need = w_pre_sat;
                end
                etsc_pkg::TK_OPEN: begin
                    if (w_stat.full) begin
                        n_err = etsc_pkg::ST_TOO_DEEP;
                    end else begin
                        w_ctrl.push = 1'b1;
                        n_left      = '0;
                        n_need      = '0;
                    end
                end
                etsc_pkg::TK_CLOSE: begin
                    if (w_stat.empty) begin
                        n_err = etsc_pkg::ST_CLOSE_EMPTY;
                    end else begin
                        if (r_need != '0) begin
                            n_err = etsc_pkg::ST_CLOSE_SHORT;
                        end
                        w_ctrl.pop = 1'b1;
                        if (w_fits) begin
                            n_left = w_out_left;
                            n_need = w_out_right - r_left;
                        end else begin
                            n_left = w_fold_sat;
                            n_need = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // level counts and first error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_need <= '0;
            r_err  <= etsc_pkg::ST_OK;
        end else begin
            r_left <= n_left;
            r_need <= n_need;
            r_err  <= n_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_status <= w_status;
        end
    end

`ifndef SYNTHESIS
    // an end marker always leaves a status waiting
    a_end_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> r_out_valid)
        else $error("end marker did not produce a status");

    // an end marker returns the checker to its reset state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (w_stat.empty && (r_err == etsc_pkg::ST_OK) && (r_left == '0)
                   && (r_need == '0)))
        else $error("end marker did not clear the checker");

    // the first error is held until the end marker
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_err != etsc_pkg::ST_OK) && !w_end) |=> (r_err == $past(r_err)))
        else $error("first error changed before the end marker");

    // a waiting status never goes beyond the deepest code
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status <= etsc_pkg::ST_TOO_DEEP))
        else $error("status code out of range");

    // the stack is never pushed while full nor popped while empty
    a_stack_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((w_ctrl.push && w_stat.full) || (w_ctrl.pop && w_stat.empty)))
        else $error("bracket stack bound violated");
`endif

endmodule

[rtl/core/etsc_stack.sv]
// bracket stack: level counter, pair memory and registered top-of-stack copy
module etsc_stack #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etsc_pkg::t_stk_ctrl i_ctrl,
    input  logic [DATA_W-1:0]   i_push_data,
    output logic [DATA_W-1:0]   o_top_data,
    output etsc_pkg::t_stk_stat o_stat
);

    localparam int LVL_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;
    logic [LVL_W-1:0]  w_rd_lvl;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [DATA_W-1:0] r_top;
    logic [DATA_W-1:0] r_mem [MEM_DEPTH];

    // next level
    always_comb begin
        priority if (i_ctrl.clear) begin
            n_level = '0;
        end else if (i_ctrl.push) begin
            n_level = r_level + LVL_W'(1);
        end else if (i_ctrl.pop) begin
            n_level = r_level - LVL_W'(1);
        end else begin
            n_level = r_level;
        end
    end

    // the top entry sits at level - 1 once the update lands
    assign w_rd_lvl  = n_level - LVL_W'(1);
    assign w_rd_addr = w_rd_lvl[ADDR_W-1:0];
    assign w_wr_addr = r_level[ADDR_W-1:0];

    // level counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    // pair memory write
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[w_wr_addr] <= i_push_data;
        end
    end

    // registered read of the new top, bypassing a pair being pushed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_top <= i_push_data;
        end else begin
            r_top <= r_mem[w_rd_addr];
        end
    end

    assign o_top_data   = r_top;
    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == LVL_W'(DEPTH));

endmodule
